/* rtl/itb_pkg.sv */
`timescale 1ns / 1ps

package itb_pkg;

   localparam int COST_BITS   = 16;
   localparam int PMAX_W      = COST_BITS + 2;
   localparam int REQ_TDATA_W = ((COST_BITS + 7) / 8) * 8;

   localparam int PATH_OUT_W  = 18;
   localparam int SET_OUT_W   = 26;
   localparam int RSP_TDATA_W = ((PATH_OUT_W + SET_OUT_W + 7) / 8) * 8;

   localparam int RECIP_W     = 32;
   localparam int SUM_W       = 41;
   localparam int STEP_W      = 6;

   localparam int RECIP_SHIFT = 32;
   localparam int SET_SHIFT   = 40;

   localparam int Q_DEPTH     = 4;
   localparam int Q_AW        = $clog2(Q_DEPTH);

   localparam logic [PATH_OUT_W-1:0] PATH_OUT_MAX = {PATH_OUT_W{1'b1}};
   localparam logic [SET_OUT_W-1:0]  SET_OUT_MAX  = {SET_OUT_W{1'b1}};
   localparam logic [RECIP_W-1:0]    RECIP_MAX    = {RECIP_W{1'b1}};
   localparam logic [SUM_W-1:0]      SUM_MAX      = {SUM_W{1'b1}};

   typedef struct packed {
      logic [PMAX_W-1:0] bound;
      logic              set_end;
   } queue_entry_type;

   typedef struct packed {
      logic              start;
      logic [STEP_W-1:0] shift;
      logic [SUM_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [SUM_W-1:0] quotient;
   } div_rsp_type;

   function automatic logic [PATH_OUT_W-1:0] sat_path(input logic [PMAX_W-1:0] bound);
      logic [PATH_OUT_W-1:0] res;
      if (64'(bound) > 64'(PATH_OUT_MAX)) begin
         res = PATH_OUT_MAX;
      end else begin
         res = PATH_OUT_W'(bound);
      end
      return res;
   endfunction

endpackage

/* rtl/itb_front.sv */
`timescale 1ns / 1ps

module itb_front
   import itb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // link_cost
   input  logic                   req_tlast,
   input  logic                   req_tuser,   // set_end
   input  logic                   q_full,
   output logic                   q_push,
   output queue_entry_type        q_entry
);

   logic [COST_BITS-1:0] older_ff, older_in;
   logic [COST_BITS-1:0] newer_ff, newer_in;
   logic [PMAX_W-1:0]    pmax_ff, pmax_in;
   logic [COST_BITS-1:0] cost;
   logic [PMAX_W-1:0]    window;
   logic [PMAX_W-1:0]    pmax_new;
   logic                 take;

   assign req_tready = !q_full;
   assign take       = req_tvalid && req_tready;
   assign cost       = req_tdata[COST_BITS-1:0];
   assign window     = PMAX_W'(older_ff) + PMAX_W'(newer_ff) + PMAX_W'(cost);
   assign pmax_new   = (window > pmax_ff) ? window : pmax_ff;

   assign q_push          = take && req_tlast;
   assign q_entry.bound   = pmax_new;
   assign q_entry.set_end = req_tuser;

   always_comb begin
      older_in = older_ff;
      newer_in = newer_ff;
      pmax_in  = pmax_ff;
      if (take) begin
         if (req_tlast) begin
            older_in = '0;
            newer_in = '0;
            pmax_in  = '0;
         end else begin
            older_in = newer_ff;
            newer_in = cost;
            pmax_in  = pmax_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         older_ff <= '0;
         newer_ff <= '0;
         pmax_ff  <= '0;
      end else begin
         older_ff <= older_in;
         newer_ff <= newer_in;
         pmax_ff  <= pmax_in;
      end
   end

endmodule

/* rtl/itb_queue.sv */
`timescale 1ns / 1ps

module itb_queue
   import itb_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  queue_entry_type push_entry,
   output logic            full,
   input  logic            pop,
   output logic            valid,
   output queue_entry_type head
);

   queue_entry_type     slot_ff [Q_DEPTH];
   logic [Q_AW-1:0]     wr_ff, wr_in;
   logic [Q_AW-1:0]     rd_ff, rd_in;
   logic [Q_AW:0]       cnt_ff, cnt_in;
   logic                do_push;
   logic                do_pop;

   assign full    = (cnt_ff == (Q_AW + 1)'(Q_DEPTH));
   assign valid   = (cnt_ff != '0);
   assign head    = slot_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_in  = do_push ? Q_AW'(wr_ff + 1'b1) : wr_ff;
      rd_in  = do_pop ? Q_AW'(rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

/* rtl/itb_div.sv */
`timescale 1ns / 1ps

module itb_div
   import itb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [SUM_W:0]    rem_ff, rem_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [SUM_W-1:0]  dvs_ff, dvs_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              lead_ff, lead_in;
   logic              done_ff, done_in;
   logic [SUM_W:0]    trial;
   logic              fits;

   assign trial = {rem_ff[SUM_W-1:0], lead_ff};
   assign fits  = (trial >= {1'b0, dvs_ff});

   assign div_rsp.busy     = (cnt_ff != '0);
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      lead_in = lead_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = '0;
         quo_in  = '0;
         dvs_in  = div_req.divisor;
         cnt_in  = div_req.shift + 1'b1;
         lead_in = 1'b1;
      end else if (cnt_ff != '0) begin
         rem_in  = fits ? (trial - {1'b0, dvs_ff}) : trial;
         quo_in  = {quo_ff[SUM_W-2:0], fits};
         lead_in = 1'b0;
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
      lead_ff <= lead_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

endmodule

/* rtl/itb_back.sv */
`timescale 1ns / 1ps

module itb_back
   import itb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  queue_entry_type        q_head,
   output logic                   q_pop,
   output div_req_type            div_req,
   input  div_rsp_type            div_rsp,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // path_bound, set_bound
   output logic                   rsp_tlast,   // set_done
   output logic                   rsp_tuser    // zero_path_seen
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RECIP,
      ST_ACCUM,
      ST_SETDIV,
      ST_EMIT
   } state_type;

   state_type              state_ff, state_in;
   logic [PMAX_W-1:0]      bound_ff, bound_in;
   logic                   send_ff, send_in;
   logic [RECIP_W-1:0]     recip_ff, recip_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic                   zflag_ff, zflag_in;
   logic [SET_OUT_W-1:0]   sb_ff, sb_in;
   div_req_type            dreq_ff, dreq_in;
   logic                   ovld_ff, ovld_in;
   logic [PATH_OUT_W-1:0]  opath_ff, opath_in;
   logic [SET_OUT_W-1:0]   oset_ff, oset_in;
   logic                   olast_ff, olast_in;
   logic                   ouser_ff, ouser_in;
   logic [SUM_W:0]         sum_wide;
   logic [SUM_W-1:0]       sum_sat;
   logic                   out_free;

   assign sum_wide = {1'b0, sum_ff} + (SUM_W + 1)'(recip_ff);
   assign sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
   assign out_free = !ovld_ff || rsp_tready;

   assign q_pop      = (state_ff == ST_IDLE) && q_valid;
   assign div_req    = dreq_ff;
   assign rsp_tvalid = ovld_ff;
   assign rsp_tdata  = RSP_TDATA_W'({oset_ff, opath_ff});
   assign rsp_tlast  = olast_ff;
   assign rsp_tuser  = ouser_ff;

   always_comb begin
      state_in      = state_ff;
      bound_in      = bound_ff;
      send_in       = send_ff;
      recip_in      = recip_ff;
      sum_in        = sum_ff;
      zflag_in      = zflag_ff;
      sb_in         = sb_ff;
      dreq_in       = dreq_ff;
      dreq_in.start = 1'b0;
      ovld_in       = ovld_ff && !rsp_tready;
      opath_in      = opath_ff;
      oset_in       = oset_ff;
      olast_in      = olast_ff;
      ouser_in      = ouser_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               bound_in = q_head.bound;
               send_in  = q_head.set_end;
               if (q_head.bound == '0) begin
                  recip_in = RECIP_MAX;
                  zflag_in = 1'b1;
                  state_in = ST_ACCUM;
               end else begin
                  dreq_in.start   = 1'b1;
                  dreq_in.shift   = STEP_W'(RECIP_SHIFT);
                  dreq_in.divisor = SUM_W'(q_head.bound);
                  state_in        = ST_RECIP;
               end
            end
         end
         ST_RECIP: begin
            if (div_rsp.done) begin
               recip_in = (div_rsp.quotient[SUM_W-1:RECIP_W] != '0) ? RECIP_MAX
                        : div_rsp.quotient[RECIP_W-1:0];
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            sum_in = sum_sat;
            sb_in  = '0;
            if (send_ff && sum_sat == '0) begin
               sb_in    = SET_OUT_MAX;
               state_in = ST_EMIT;
            end else if (send_ff) begin
               dreq_in.start   = 1'b1;
               dreq_in.shift   = STEP_W'(SET_SHIFT);
               dreq_in.divisor = sum_sat;
               state_in        = ST_SETDIV;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_SETDIV: begin
            if (div_rsp.done) begin
               sb_in    = (div_rsp.quotient[SUM_W-1:SET_OUT_W] != '0) ? SET_OUT_MAX
                        : div_rsp.quotient[SET_OUT_W-1:0];
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               ovld_in  = 1'b1;
               opath_in = sat_path(bound_ff);
               oset_in  = sb_ff;
               olast_in = send_ff;
               ouser_in = zflag_ff;
               if (send_ff) begin
                  sum_in   = '0;
                  zflag_in = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      bound_ff        <= bound_in;
      send_ff         <= send_in;
      recip_ff        <= recip_in;
      sb_ff           <= sb_in;
      dreq_ff.shift   <= dreq_in.shift;
      dreq_ff.divisor <= dreq_in.divisor;
      opath_ff        <= opath_in;
      oset_ff         <= oset_in;
      olast_ff        <= olast_in;
      ouser_ff        <= ouser_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         sum_ff        <= '0;
         zflag_ff      <= 1'b0;
         dreq_ff.start <= 1'b0;
         ovld_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sum_ff        <= sum_in;
         zflag_ff      <= zflag_in;
         dreq_ff.start <= dreq_in.start;
         ovld_ff       <= ovld_in;
      end
   end

`ifndef SYNTH
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      dreq_ff.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   a_set_bound_only_last: assert property (@(posedge clock) disable iff (reset)
      ovld_ff |-> (olast_ff || oset_ff == '0))
      else $error("set bound on a result that does not close a set");

   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_free) |=> (ovld_ff && state_ff == ST_IDLE))
      else $error("result not loaded on emit");

   a_sum_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_free && send_ff) |=> (sum_ff == '0 && !zflag_ff))
      else $error("set state not cleared after last path");
`endif

endmodule

/* rtl/interflow_three_hop_bound.sv */
`timescale 1ns / 1ps
// Sequence: each path is queued, then the back end divides for its reciprocal and accumulates it;
// the last path of a set takes a second divide for the set bound (bit-serial divider, 33 or 41
// steps); a path with zero bound skips the first divide.
// Throughput: one link per cycle while the 4-entry path queue has room; the back end takes a
// new path only after it has emitted the last one, and stalls while rsp_tready is low.
// Reset: synchronous, active high; clears window, sums, flags, queue and output valid.

module interflow_three_hop_bound
   import itb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // link_cost
   input  logic                   req_tlast,   // path_end
   input  logic                   req_tuser,   // set_end
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // path_bound, set_bound
   output logic                   rsp_tlast,   // set_done
   output logic                   rsp_tuser    // zero_path_seen
);

   logic            q_full;
   logic            q_push;
   queue_entry_type q_in;
   logic            q_pop;
   logic            q_valid;
   queue_entry_type q_head;
   div_req_type     div_req;
   div_rsp_type     div_rsp;

   itb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (q_in)
   );

   itb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in),
      .full       (q_full),
      .pop        (q_pop),
      .valid      (q_valid),
      .head       (q_head)
   );

   itb_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   itb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .div_req    (div_req),
      .div_rsp    (div_rsp),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
